// File: hw/rtl/dual_sine_table_generator_assert.svh
// Assertion macros used by dsg_checker.sv.
`ifndef DUAL_SINE_TABLE_GENERATOR_ASSERT_SVH
`define DUAL_SINE_TABLE_GENERATOR_ASSERT_SVH

// Same-cycle implication.
`define DSG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dsg assertion failed");

// Next-cycle implication.
`define DSG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dsg assertion failed");

`endif

// File: hw/rtl/dsg_pkg.sv
`default_nettype none

package dsg_pkg;

  localparam int unsigned IDX_W   = 7;
  localparam int unsigned CODE_W  = 12;
  localparam int unsigned AMP_W   = 12;
  localparam int unsigned PHASE_W = 9;
  localparam int unsigned MAG_W   = 11;
  localparam int unsigned PROD_W  = MAG_W + AMP_W;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned TAB_LEN = 128;

  localparam logic [CODE_W-1:0]  MID_CODE   = 12'd2048;
  localparam logic [CODE_W-1:0]  MAX_CODE   = 12'd4095;
  localparam logic [PHASE_W-1:0] PHASE_WRAP = 9'd360;

  // floor(x / 45) = (x * OFFS_RECIP) >> OFFS_SHIFT for x < 5760
  localparam logic [18:0] OFFS_RECIP = 19'd372828;
  localparam int unsigned OFFS_SHIFT = 24;

  // Reciprocal scaling of the product by the full-scale amplitude
  localparam int unsigned RECIP_SHIFT = 35;
  localparam int unsigned RECIP_SPLIT = 18;

  typedef enum logic [ADDR_W-1:0] {
    REG_DUAL_MODE = 3'd0,
    REG_AMP_CH1   = 3'd1,
    REG_PHASE_CH1 = 3'd2,
    REG_AMP_CH2   = 3'd3,
    REG_PHASE_CH2 = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic s2;
    logic s3;
  } stage_en_t;

  localparam logic [CODE_W-1:0] SINE_TAB [TAB_LEN] = '{
    12'd2048, 12'd2148, 12'd2249, 12'd2348, 12'd2447, 12'd2545, 12'd2642, 12'd2738,
    12'd2831, 12'd2923, 12'd3013, 12'd3100, 12'd3185, 12'd3267, 12'd3347, 12'd3423,
    12'd3495, 12'd3565, 12'd3630, 12'd3692, 12'd3750, 12'd3804, 12'd3853, 12'd3898,
    12'd3939, 12'd3975, 12'd4007, 12'd4034, 12'd4056, 12'd4073, 12'd4085, 12'd4093,
    12'd4095, 12'd4093, 12'd4085, 12'd4073, 12'd4056, 12'd4034, 12'd4007, 12'd3975,
    12'd3939, 12'd3898, 12'd3853, 12'd3804, 12'd3750, 12'd3692, 12'd3630, 12'd3565,
    12'd3495, 12'd3423, 12'd3347, 12'd3267, 12'd3185, 12'd3100, 12'd3013, 12'd2923,
    12'd2831, 12'd2738, 12'd2642, 12'd2545, 12'd2447, 12'd2348, 12'd2249, 12'd2148,
    12'd2048, 12'd1948, 12'd1847, 12'd1748, 12'd1649, 12'd1551, 12'd1454, 12'd1358,
    12'd1265, 12'd1173, 12'd1083, 12'd996,  12'd911,  12'd829,  12'd749,  12'd673,
    12'd601,  12'd531,  12'd466,  12'd404,  12'd346,  12'd292,  12'd243,  12'd198,
    12'd157,  12'd121,  12'd89,   12'd62,   12'd40,   12'd23,   12'd11,   12'd3,
    12'd1,    12'd3,    12'd11,   12'd23,   12'd40,   12'd62,   12'd89,   12'd121,
    12'd157,  12'd198,  12'd243,  12'd292,  12'd346,  12'd404,  12'd466,  12'd531,
    12'd601,  12'd673,  12'd749,  12'd829,  12'd911,  12'd996,  12'd1083, 12'd1173,
    12'd1265, 12'd1358, 12'd1454, 12'd1551, 12'd1649, 12'd1748, 12'd1847, 12'd1948
  };

  // Phase in degrees -> table offset, phase * 128 / 360 after wrapping at 360
  function automatic logic [IDX_W-1:0] phase_offset(logic [PHASE_W-1:0] raw);
    logic [PHASE_W-1:0] ph;
    logic [31:0]        x;
    logic [31:0]        p;
    ph = (raw >= PHASE_WRAP) ? raw - PHASE_WRAP : raw;
    x  = {19'd0, ph, 4'd0};
    p  = x * {13'd0, OFFS_RECIP};
    return p[OFFS_SHIFT +: IDX_W];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/dsg_scale.sv
`default_nettype none

module dsg_scale #(
  parameter int unsigned FULL_SCALE_AMP = 4095
) (
  input  wire logic                          clk_i,
  input  wire dsg_pkg::stage_en_t            en_i,
  input  wire logic [dsg_pkg::IDX_W-1:0]     idx_i,
  input  wire logic [dsg_pkg::AMP_W-1:0]     amp_i,
  output logic      [dsg_pkg::CODE_W-1:0]    code_o
);

  localparam logic [63:0] DIVISOR = 64'(FULL_SCALE_AMP);
  localparam logic [63:0] RECIP   =
    ((64'd1 << dsg_pkg::RECIP_SHIFT) + DIVISOR - 64'd1) / DIVISOR;
  localparam int unsigned HALF_W  = dsg_pkg::RECIP_SPLIT;
  localparam int unsigned PP_W    = dsg_pkg::PROD_W + HALF_W;
  localparam int unsigned SUM_W   = PP_W + HALF_W + 1;
  localparam logic [HALF_W-1:0] RECIP_LO = RECIP[HALF_W-1:0];
  localparam logic [HALF_W-1:0] RECIP_HI = RECIP[2*HALF_W-1:HALF_W];

  logic [dsg_pkg::CODE_W-1:0] tab;
  logic                       neg;
  logic [dsg_pkg::CODE_W-1:0] diff;
  logic [dsg_pkg::PROD_W-1:0] prod_d, prod_q;
  logic                       neg2_q, neg3_q;
  logic [PP_W-1:0]            plo_d, phi_d, plo_q, phi_q;
  logic [SUM_W-1:0]           sum;
  logic [dsg_pkg::CODE_W-1:0] quo;
  logic [dsg_pkg::CODE_W:0]   up, dn;

  // stage 2: table read and amplitude product
  always_comb begin
    tab    = dsg_pkg::SINE_TAB[idx_i];
    neg    = tab < dsg_pkg::MID_CODE;
    diff   = neg ? dsg_pkg::MID_CODE - tab : tab - dsg_pkg::MID_CODE;
    prod_d = {12'd0, diff[dsg_pkg::MAG_W-1:0]} * {11'd0, amp_i};
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      prod_q <= prod_d;
      neg2_q <= neg;
    end
  end

  // stage 3: reciprocal multiply split into two partial products
  always_comb begin
    plo_d = {{HALF_W{1'b0}}, prod_q} * {{dsg_pkg::PROD_W{1'b0}}, RECIP_LO};
    phi_d = {{HALF_W{1'b0}}, prod_q} * {{dsg_pkg::PROD_W{1'b0}}, RECIP_HI};
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      plo_q  <= plo_d;
      phi_q  <= phi_d;
      neg3_q <= neg2_q;
    end
  end

  // recombine, truncate toward zero, recenter and clamp
  always_comb begin
    sum = {1'b0, phi_q, {HALF_W{1'b0}}} + {{(HALF_W + 1){1'b0}}, plo_q};
    quo = sum[dsg_pkg::RECIP_SHIFT +: dsg_pkg::CODE_W];
    up  = {1'b0, dsg_pkg::MID_CODE} + {1'b0, quo};
    dn  = {1'b0, dsg_pkg::MID_CODE} - {1'b0, quo};
    if (neg3_q) begin
      code_o = dn[dsg_pkg::CODE_W] ? '0 : dn[dsg_pkg::CODE_W-1:0];
    end else begin
      code_o = up[dsg_pkg::CODE_W] ? dsg_pkg::MAX_CODE : up[dsg_pkg::CODE_W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/dual_sine_table_generator.sv
// Two-channel lookup-table sine generator for 12-bit DACs.
// Input stream: one tick per transfer; tdata[0] steps channel 1, tdata[1]
// steps channel 2. Output stream: one result per input transfer carrying
// both held DAC codes and the per-channel update flags.
// A stepped channel reads the shared 128-entry sine table at position plus
// phase offset, scales the deviation from midscale by amplitude / full scale
// (truncating toward zero), and advances its position. In single mode a
// stepped channel 2 drives midscale.
// Pipeline: the input register, product, reciprocal partial products and
// output register hold each result in turn. Throughput: one item per
// cycle while the receiver accepts; the stages hand off independently, so
// empty stages keep accepting while a finished result waits at the output.
// Configuration: cfg_we_i writes register cfg_addr_i (0 dual mode, 1/3
// amplitude, 2/4 phase in degrees); a write to one of these five returns
// both positions to zero. Write only while the pipeline is empty.
// Reset: positions and held codes go to 0, amplitudes to min(2048, full
// scale), phases to 0, single mode. A stalled receiver holds the output
// register; backpressure reaches the input once all stages are full.
`default_nettype none

module dual_sine_table_generator #(
  parameter int unsigned FULL_SCALE_AMP = 4095
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // [0] step_ch1, [1] step_ch2
  input  wire logic [7:0]                    s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [11:0] sample_ch1, [23:12] sample_ch2, [24] updated_ch1, [25] updated_ch2
  output logic      [31:0]                   m_axis_tdata,
  input  wire logic                          cfg_we_i,
  input  wire logic [dsg_pkg::ADDR_W-1:0]    cfg_addr_i,
  input  wire logic [dsg_pkg::AMP_W-1:0]     cfg_wdata_i
);

  localparam logic [dsg_pkg::AMP_W-1:0] AMP_MAX = dsg_pkg::AMP_W'(FULL_SCALE_AMP);
  localparam logic [dsg_pkg::AMP_W-1:0] AMP_RST =
    (AMP_MAX < 12'd2048) ? AMP_MAX : 12'd2048;

  logic                       dual_q;
  logic [dsg_pkg::AMP_W-1:0]  amp1_q, amp2_q, amp_sat;
  logic [dsg_pkg::IDX_W-1:0]  offs1_q, offs2_q, offs_new;
  logic [dsg_pkg::IDX_W-1:0]  pos1_q, pos2_q;
  logic [dsg_pkg::IDX_W-1:0]  idx1_q, idx2_q;
  logic [1:0]                 upd_s1_q, upd_s2_q, upd_s3_q, upd_o_q;
  logic                       v1_q, v2_q, v3_q, vo_q;
  logic                       out_rdy, r3, r2, r1, in_xfer, out_load, cfg_hit;
  logic [dsg_pkg::CODE_W-1:0] code1, code2;
  logic [dsg_pkg::CODE_W-1:0] sample1_q, sample2_q;
  dsg_pkg::stage_en_t         en;

  assign out_rdy = !vo_q || m_axis_tready;
  assign r3      = !v3_q || out_rdy;
  assign r2      = !v2_q || r3;
  assign r1      = !v1_q || r2;
  assign in_xfer = s_axis_tvalid && r1;
  assign out_load = v3_q && out_rdy;

  always_comb begin
    en.s2 = v1_q && r2;
    en.s3 = v2_q && r3;
  end

  assign s_axis_tready = r1;
  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = {6'd0, upd_o_q, sample2_q, sample1_q};

  assign amp_sat  = (cfg_wdata_i > AMP_MAX) ? AMP_MAX : cfg_wdata_i;
  assign offs_new = dsg_pkg::phase_offset(cfg_wdata_i[dsg_pkg::PHASE_W-1:0]);

  always_comb begin
    unique case (cfg_addr_i)
      dsg_pkg::REG_DUAL_MODE,
      dsg_pkg::REG_AMP_CH1,
      dsg_pkg::REG_PHASE_CH1,
      dsg_pkg::REG_AMP_CH2,
      dsg_pkg::REG_PHASE_CH2: cfg_hit = cfg_we_i;
      default:                cfg_hit = 1'b0;
    endcase
  end

  // configuration and table positions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dual_q  <= 1'b0;
      amp1_q  <= AMP_RST;
      amp2_q  <= AMP_RST;
      offs1_q <= '0;
      offs2_q <= '0;
      pos1_q  <= '0;
      pos2_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          dsg_pkg::REG_DUAL_MODE: dual_q  <= cfg_wdata_i[0];
          dsg_pkg::REG_AMP_CH1:   amp1_q  <= amp_sat;
          dsg_pkg::REG_PHASE_CH1: offs1_q <= offs_new;
          dsg_pkg::REG_AMP_CH2:   amp2_q  <= amp_sat;
          dsg_pkg::REG_PHASE_CH2: offs2_q <= offs_new;
          default: ;
        endcase
      end
      if (cfg_hit) begin
        pos1_q <= '0;
        pos2_q <= '0;
      end else if (in_xfer) begin
        if (s_axis_tdata[0]) pos1_q <= pos1_q + 7'd1;
        if (s_axis_tdata[1]) pos2_q <= pos2_q + 7'd1;
      end
    end
  end

  // pipeline control and held codes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      vo_q      <= 1'b0;
      sample1_q <= '0;
      sample2_q <= '0;
    end else begin
      if (r1) v1_q <= s_axis_tvalid;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (out_rdy) vo_q <= v3_q;
      if (out_load) begin
        if (upd_s3_q[0]) sample1_q <= code1;
        if (upd_s3_q[1]) sample2_q <= dual_q ? code2 : dsg_pkg::MID_CODE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      upd_s1_q <= s_axis_tdata[1:0];
      idx1_q   <= pos1_q + offs1_q;
      idx2_q   <= pos2_q + offs2_q;
    end
    if (en.s2) upd_s2_q <= upd_s1_q;
    if (en.s3) upd_s3_q <= upd_s2_q;
    if (out_load) upd_o_q <= upd_s3_q;
  end

  dsg_scale #(
    .FULL_SCALE_AMP(FULL_SCALE_AMP)
  ) u_scale_ch1 (
    .clk_i (clk_i),
    .en_i  (en),
    .idx_i (idx1_q),
    .amp_i (amp1_q),
    .code_o(code1)
  );

  dsg_scale #(
    .FULL_SCALE_AMP(FULL_SCALE_AMP)
  ) u_scale_ch2 (
    .clk_i (clk_i),
    .en_i  (en),
    .idx_i (idx2_q),
    .amp_i (amp2_q),
    .code_o(code2)
  );

endmodule

`default_nettype wire

// File: hw/rtl/dsg_checker.sv
`default_nettype none

`include "dual_sine_table_generator_assert.svh"

module dsg_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       s_axis_tvalid,
  input wire logic                       s_axis_tready,
  input wire logic                       m_axis_tvalid,
  input wire logic                       m_axis_tready,
  input wire logic [31:0]                m_axis_tdata,
  input wire logic                       cfg_we_i,
  input wire logic [dsg_pkg::ADDR_W-1:0] cfg_addr_i,
  input wire logic [dsg_pkg::AMP_W-1:0]  cfg_wdata_i
);

  logic                       in_xfer, out_xfer;
  logic [2:0]                 fill_q;
  logic                       mode_q;
  logic [dsg_pkg::CODE_W-1:0] last1_q, last2_q;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      mode_q  <= 1'b0;
      last1_q <= '0;
      last2_q <= '0;
    end else begin
      fill_q <= fill_q + {2'd0, in_xfer} - {2'd0, out_xfer};
      if (cfg_we_i && cfg_addr_i == dsg_pkg::REG_DUAL_MODE) mode_q <= cfg_wdata_i[0];
      if (out_xfer) begin
        last1_q <= m_axis_tdata[11:0];
        last2_q <= m_axis_tdata[23:12];
      end
    end
  end

  `DSG_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `DSG_ASSERT_IMP(a_fill_bound, clk_i, rst_ni, 1'b1, fill_q <= 3'd4)
  `DSG_ASSERT_IMP(a_no_phantom, clk_i, rst_ni, m_axis_tvalid, fill_q != 3'd0)
  `DSG_ASSERT_IMP(a_held, clk_i, rst_ni, out_xfer, (m_axis_tdata[24] || m_axis_tdata[11:0] == last1_q) && (m_axis_tdata[25] || m_axis_tdata[23:12] == last2_q))
  `DSG_ASSERT_IMP(a_single_mid, clk_i, rst_ni, out_xfer && m_axis_tdata[25] && !mode_q, m_axis_tdata[23:12] == dsg_pkg::MID_CODE)

endmodule

bind dual_sine_table_generator dsg_checker u_dsg_checker (.*);

`default_nettype wire

// File: verif/dual_sine_table_generator_checker.sv
module dual_sine_table_generator_checker
  import dsg_pkg::*;
#(
  parameter int unsigned FULL_SCALE_AMP = 4095
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  // [0] step_ch1, [1] step_ch2
  input  logic [7:0]          s_tdata_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  // [11:0] sample_ch1, [23:12] sample_ch2, [24] updated_ch1, [25] updated_ch2
  input  logic [31:0]         m_tdata_i,
  input  logic                cfg_we_i,
  input  logic [ADDR_W-1:0]   cfg_addr_i,
  input  logic [AMP_W-1:0]    cfg_wdata_i,
  output int                  errors_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MID_LEVEL  = 2048;
  localparam int TOP_LEVEL  = 4095;
  localparam int ROM_DEPTH  = 128;
  localparam int DEG_PER_TURN = 360;

  localparam int WAVE_ROM [ROM_DEPTH] = '{
    2048, 2148, 2249, 2348, 2447, 2545, 2642, 2738,
    2831, 2923, 3013, 3100, 3185, 3267, 3347, 3423,
    3495, 3565, 3630, 3692, 3750, 3804, 3853, 3898,
    3939, 3975, 4007, 4034, 4056, 4073, 4085, 4093,
    4095, 4093, 4085, 4073, 4056, 4034, 4007, 3975,
    3939, 3898, 3853, 3804, 3750, 3692, 3630, 3565,
    3495, 3423, 3347, 3267, 3185, 3100, 3013, 2923,
    2831, 2738, 2642, 2545, 2447, 2348, 2249, 2148,
    2048, 1948, 1847, 1748, 1649, 1551, 1454, 1358,
    1265, 1173, 1083, 996,  911,  829,  749,  673,
    601,  531,  466,  404,  346,  292,  243,  198,
    157,  121,  89,   62,   40,   23,   11,   3,
    1,    3,    11,   23,   40,   62,   89,   121,
    157,  198,  243,  292,  346,  404,  466,  531,
    601,  673,  749,  829,  911,  996,  1083, 1173,
    1265, 1358, 1454, 1551, 1649, 1748, 1847, 1948
  };

  // packed from the top bit down: updated_ch2 lands at bit 25, sample_ch1 at [11:0]
  typedef struct packed {
    logic              updated_ch2;
    logic              updated_ch1;
    logic [CODE_W-1:0] sample_ch2;
    logic [CODE_W-1:0] sample_ch1;
  } dac_result_t;

  logic               dual_mode_q;
  logic [AMP_W-1:0]   amp_ch1_q;
  logic [AMP_W-1:0]   amp_ch2_q;
  logic [PHASE_W-1:0] phase_ch1_q;
  logic [PHASE_W-1:0] phase_ch2_q;
  logic [IDX_W-1:0]   pos_ch1_q;
  logic [IDX_W-1:0]   pos_ch2_q;
  logic [CODE_W-1:0]  held_ch1_q;
  logic [CODE_W-1:0]  held_ch2_q;
  dac_result_t        dac_expect_q[$];
  int                 mismatch_cnt = 0;

  assign errors_o = mismatch_cnt;

  function automatic logic [AMP_W-1:0] clip_amplitude(logic [AMP_W-1:0] raw);
    return (int'(raw) > int'(FULL_SCALE_AMP)) ? AMP_W'(FULL_SCALE_AMP) : raw;
  endfunction

  function automatic logic [PHASE_W-1:0] wrap_degrees(logic [AMP_W-1:0] raw);
    return PHASE_W'(int'(raw[PHASE_W-1:0]) % DEG_PER_TURN);
  endfunction

  function automatic logic [CODE_W-1:0] dac_code(logic [IDX_W-1:0] pos,
                                                 logic [PHASE_W-1:0] phase,
                                                 logic [AMP_W-1:0] amp);
    int               offs;
    int               dev;
    int               level;
    logic [IDX_W-1:0] idx;
    offs  = (int'(phase) * ROM_DEPTH) / DEG_PER_TURN;
    idx   = IDX_W'(int'(pos) + offs);
    dev   = WAVE_ROM[idx] - MID_LEVEL;
    level = MID_LEVEL + (dev * int'(amp)) / int'(FULL_SCALE_AMP);
    if (level < 0) level = 0;
    if (level > TOP_LEVEL) level = TOP_LEVEL;
    return CODE_W'(level);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_cnt++;
  endtask

  always @(posedge clk_i) begin : monitor
    dac_result_t got;
    dac_result_t want;
    if (!rst_ni) begin
      dual_mode_q = 1'b0;
      amp_ch1_q   = clip_amplitude(AMP_W'(MID_LEVEL));
      amp_ch2_q   = clip_amplitude(AMP_W'(MID_LEVEL));
      phase_ch1_q = '0;
      phase_ch2_q = '0;
      pos_ch1_q   = '0;
      pos_ch2_q   = '0;
      held_ch1_q  = '0;
      held_ch2_q  = '0;
      dac_expect_q.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i[25:0];
        if (dac_expect_q.size() == 0) begin
          report_mismatch($sformatf("result transfer with none expected, data %h", m_tdata_i));
        end else begin
          want = dac_expect_q.pop_front();
          if (got.sample_ch1 !== want.sample_ch1)
            report_mismatch($sformatf("sample_ch1 got %0d expected %0d",
                                      got.sample_ch1, want.sample_ch1));
          if (got.sample_ch2 !== want.sample_ch2)
            report_mismatch($sformatf("sample_ch2 got %0d expected %0d",
                                      got.sample_ch2, want.sample_ch2));
          if (got.updated_ch1 !== want.updated_ch1)
            report_mismatch($sformatf("updated_ch1 got %b expected %b",
                                      got.updated_ch1, want.updated_ch1));
          if (got.updated_ch2 !== want.updated_ch2)
            report_mismatch($sformatf("updated_ch2 got %b expected %b",
                                      got.updated_ch2, want.updated_ch2));
          if (m_tdata_i[31:26] !== '0)
            report_mismatch($sformatf("padding bits got %b", m_tdata_i[31:26]));
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        if (s_tdata_i[0]) begin
          held_ch1_q = dac_code(pos_ch1_q, phase_ch1_q, amp_ch1_q);
          pos_ch1_q  = pos_ch1_q + 1'b1;
        end
        if (s_tdata_i[1]) begin
          held_ch2_q = dual_mode_q ? dac_code(pos_ch2_q, phase_ch2_q, amp_ch2_q)
                                   : CODE_W'(MID_LEVEL);
          pos_ch2_q  = pos_ch2_q + 1'b1;
        end
        want.sample_ch1  = held_ch1_q;
        want.sample_ch2  = held_ch2_q;
        want.updated_ch1 = s_tdata_i[0];
        want.updated_ch2 = s_tdata_i[1];
        dac_expect_q.push_back(want);
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_addr_i))
          REG_DUAL_MODE: dual_mode_q = cfg_wdata_i[0];
          REG_AMP_CH1:   amp_ch1_q   = clip_amplitude(cfg_wdata_i);
          REG_PHASE_CH1: phase_ch1_q = wrap_degrees(cfg_wdata_i);
          REG_AMP_CH2:   amp_ch2_q   = clip_amplitude(cfg_wdata_i);
          REG_PHASE_CH2: phase_ch2_q = wrap_degrees(cfg_wdata_i);
          default: ;
        endcase
        if (int'(cfg_addr_i) <= int'(REG_PHASE_CH2)) begin
          pos_ch1_q = '0;
          pos_ch2_q = '0;
        end
      end
    end
    pending_o <= dac_expect_q.size();
  end

endmodule

// File: verif/tb_dual_sine_table_generator.sv
module tb_dual_sine_table_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import dsg_pkg::*;

  localparam int unsigned     FULL_SCALE  = 4095;
  localparam int              FLUSH_WAIT  = 8;
  localparam int              LONG_HOLD   = 60;
  localparam int              NUM_PHASES  = 12;
  localparam int              TICKS_PER_PHASE = 120;
  localparam logic [ADDR_W-1:0] BAD_ADDR_LO = 3'd5;
  localparam logic [ADDR_W-1:0] BAD_ADDR_HI = 3'd7;
  localparam logic [AMP_W-1:0]  AMP_TOP     = 12'hFFF;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic [7:0]        s_axis_tdata  = '0;
  logic              m_axis_tready = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [ADDR_W-1:0] cfg_addr_i    = '0;
  logic [AMP_W-1:0]  cfg_wdata_i   = '0;
  logic              s_axis_tready;
  logic              m_axis_tvalid;
  logic [31:0]       m_axis_tdata;

  int src_idle_pct  = 26;
  int snk_idle_pct  = 87;
  int hold_req_cnt  = 0;
  int hold_ack_cnt  = 0;
  int hold_left     = 0;
  int mismatches;
  int results_pending;

  dual_sine_table_generator #(
    .FULL_SCALE_AMP(FULL_SCALE)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  dual_sine_table_generator_checker #(
    .FULL_SCALE_AMP(FULL_SCALE)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .errors_o    (mismatches),
    .pending_o   (results_pending)
  );

  always #6 clk_i = ~clk_i;

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_ack_cnt != hold_req_cnt) begin
      hold_ack_cnt  <= hold_req_cnt;
      hold_left     <= LONG_HOLD - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  task automatic send_tick(input logic step1, input logic step2);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, step2, step1};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (results_pending != 0);
    repeat (FLUSH_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [AMP_W-1:0] data);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [AMP_W-1:0] pick_amplitude();
    case ($urandom_range(3))
      0:       return '0;
      1:       return AMP_TOP;
      default: return AMP_W'($urandom);
    endcase
  endfunction

  function automatic logic [AMP_W-1:0] pick_phase();
    case ($urandom_range(4))
      0:       return '0;
      1:       return 12'd359;
      2:       return AMP_W'($urandom_range(511, 360));
      default: return AMP_W'($urandom_range(511));
    endcase
  endfunction

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config: single mode, half amplitude; first tick reports zero codes
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    write_reg(REG_DUAL_MODE, AMP_TOP);
    repeat (3) send_tick(1'b1, 1'b1);
    write_reg(REG_AMP_CH1, AMP_TOP);
    write_reg(REG_AMP_CH2, '0);
    repeat (2) send_tick(1'b1, 1'b1);
    write_reg(REG_PHASE_CH1, 12'd359);
    write_reg(REG_PHASE_CH2, 12'd360);
    repeat (2) send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    // unmapped index must leave positions alone
    write_reg(BAD_ADDR_LO, 12'h155);
    send_tick(1'b1, 1'b1);
    write_reg(BAD_ADDR_HI, '0);
    send_tick(1'b1, 1'b1);
    write_reg(REG_PHASE_CH2, 12'd511);
    write_reg(REG_PHASE_CH1, 12'd90);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    write_reg(REG_DUAL_MODE, 12'hFFE);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    write_reg(REG_AMP_CH1, 12'd1);
    send_tick(1'b1, 1'b1);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      src_idle_pct = (ph < 4) ? 26 : (ph < 8) ? 87 : 0;
      snk_idle_pct = (ph < 4) ? 87 : (ph < 8) ? 26 : 0;
      write_reg(REG_DUAL_MODE, AMP_W'($urandom));
      write_reg(REG_AMP_CH1, pick_amplitude());
      write_reg(REG_PHASE_CH1, pick_phase());
      write_reg(REG_AMP_CH2, pick_amplitude());
      write_reg(REG_PHASE_CH2, pick_phase());
      if ($urandom_range(2) == 0)
        write_reg(ADDR_W'($urandom_range(BAD_ADDR_HI, BAD_ADDR_LO)), AMP_W'($urandom));
      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        if (n == 40 && (ph % 4) == 1) hold_req_cnt++;
        send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("tb_dual_sine_table_generator passed");
    end else begin
      $display("tb_dual_sine_table_generator failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_dual_sine_table_generator failed");
    $finish;
  end

endmodule

// File: dual_sine_table_generator.f
+incdir+hw/rtl
hw/rtl/dsg_pkg.sv
hw/rtl/dsg_scale.sv
hw/rtl/dual_sine_table_generator.sv
hw/rtl/dsg_checker.sv
verif/dual_sine_table_generator_checker.sv
verif/tb_dual_sine_table_generator.sv
